>>> sv/ctt_pkg.sv
// Shared parameters and codes for the centroid track table.
package ctt_pkg;
    localparam int COORD_BITS = 12;

    localparam logic [1:0] MODE_OBSERVE = 2'd0;
    localparam logic [1:0] MODE_CLEAR   = 2'd1;
    localparam logic [1:0] MODE_FRAME   = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    localparam logic [2:0] OUT_TRACKED  = 3'd0;
    localparam logic [2:0] OUT_DETECTED = 3'd1;
    localparam logic [2:0] OUT_CREATED  = 3'd2;
    localparam logic [2:0] OUT_FULL     = 3'd3;
    localparam logic [2:0] OUT_DONE     = 3'd4;

    localparam logic [2:0] REG_GATE  = 3'd0;
    localparam logic [2:0] REG_RATIO = 3'd1;
    localparam logic [2:0] REG_LIMIT = 3'd2;
    localparam logic [2:0] REG_BEGIN = 3'd3;
    localparam logic [2:0] REG_STOP  = 3'd4;
endpackage

>>> sv/ctt_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/centroid_track_table_unit.sv
// Centroid track table: top level with entry scan sequencer.
// Scan all SLOTS entries one per cycle, fetch and write the chosen entry, then count over SLOTS.
// One item at a time: the done strobe follows the scan, drain, fetch, write, count and done states.
// Busy holds from acceptance until the strobe; a new transaction is taken only when idle.
// Reset clears the valid bits and loads register defaults; RAM contents wait for a write.
// The result strobe lasts one cycle and cannot be stalled.
module centroid_track_table_unit
    import ctt_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                mode,
    input  logic [COORD_BITS-1:0]     x_coord,
    input  logic [COORD_BITS-1:0]     y_coord,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [47:0]               cfg_data,
    output logic                      done,
    output logic [2:0]                outcome,
    output logic [$clog2(SLOTS)-1:0]  slot,
    output logic [$clog2(SLOTS):0]    tracked_count,
    output logic [$clog2(SLOTS):0]    detected_count
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam int EW = 2 + 2 * COORD_BITS + 2 * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_FETCH, S_WRITE, S_COUNT, S_DONE
    } state_t;

    typedef struct packed {
        logic                  tracked;
        logic                  seen;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COUNT_BITS-1:0] hits;
        logic [COUNT_BITS-1:0] misses;
    } entry_t;

    state_t state_reg;
    logic [23:0] gate_reg;
    logic [7:0]  ratio_reg;
    logic [15:0] limit_reg;
    logic [47:0] begin_reg, stop_reg;
    logic [SLOTS-1:0] valid_reg, tracked_reg;
    logic [1:0] mode_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [CW-1:0] rd_ptr_reg, cnt_ptr_reg;
    logic [AW-1:0] cur_reg;
    logic cur_v_reg;
    logic bt_v_reg, bd_v_reg, free_v_reg;
    logic [AW-1:0] bt_reg, bd_reg, free_reg;
    logic [2*COORD_BITS:0] dt_reg, dd_reg;
    logic [CW-1:0] tc_reg, dc_reg;
    logic [2:0] outcome_reg;
    logic [AW-1:0] slot_reg;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t ram_wdata, ram_rdata, upd;

    ctt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entries (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    function automatic logic in_rect(input logic [47:0] r, input logic [COORD_BITS-1:0] px,
                                     input logic [COORD_BITS-1:0] py);
        logic [COORD_BITS-1:0] l, t, rr, b;
        l  = r[COORD_BITS-1:0];
        t  = r[2*COORD_BITS-1:COORD_BITS];
        rr = r[3*COORD_BITS-1:2*COORD_BITS];
        b  = r[4*COORD_BITS-1:3*COORD_BITS];
        return (px >= l) && (px < rr) && (py >= t) && (py < b);
    endfunction

    function automatic entry_t bump(input entry_t e);
        entry_t r;
        r = e;
        if (e.seen)
        begin
            r.misses = '0;
            if (e.hits != CMAX) r.hits = e.hits + 1'b1;
        end
        else if (e.misses != CMAX)
        begin
            r.misses = e.misses + 1'b1;
        end
        return r;
    endfunction

    logic [COORD_BITS-1:0] adx, ady;
    logic [2*COORD_BITS-1:0] sqx, sqy;
    logic [2*COORD_BITS:0] dsq;
    logic in_gate, promote, drop;
    logic [COUNT_BITS+7:0] noise_prod;

    always_comb
    begin
        adx = (ram_rdata.x > x_reg) ? ram_rdata.x - x_reg : x_reg - ram_rdata.x;
        ady = (ram_rdata.y > y_reg) ? ram_rdata.y - y_reg : y_reg - ram_rdata.y;
        sqx = (2 * COORD_BITS)'(adx) * (2 * COORD_BITS)'(adx);
        sqy = (2 * COORD_BITS)'(ady) * (2 * COORD_BITS)'(ady);
        dsq = {1'b0, sqx} + {1'b0, sqy};
        in_gate = ({{(48 - 2 * COORD_BITS - 1){1'b0}}, dsq} < {24'd0, gate_reg});
        upd = bump(ram_rdata);
        promote = !ram_rdata.tracked && in_rect(begin_reg, ram_rdata.x, ram_rdata.y);
        if (promote || ram_rdata.tracked)
        begin
            if (promote) upd = bump(upd);
            upd.tracked = 1'b1;
        end
        noise_prod = (COUNT_BITS + 8)'(ratio_reg) * (COUNT_BITS + 8)'(upd.misses);
        drop = (promote || ram_rdata.tracked) &&
            (((upd.misses != '0) && ({8'd0, upd.hits} < noise_prod)) ||
             ((32'(upd.misses) > 32'(limit_reg)) &&
              !in_rect(stop_reg, ram_rdata.x, ram_rdata.y)));
    end

    logic pick_v, pick_d;
    logic [AW-1:0] pick;
    always_comb
    begin
        pick_v = bt_v_reg || bd_v_reg;
        pick_d = bd_v_reg && (!bt_v_reg || ({1'b0, dt_reg} > {dd_reg, 1'b0}));
        pick = pick_d ? bd_reg : bt_reg;
    end

    always_comb
    begin
        ram_raddr = rd_ptr_reg[AW-1:0];
        ram_we = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = ram_rdata;
        if (state_reg == S_SCAN || state_reg == S_DRAIN)
        begin
            if (cur_v_reg && valid_reg[cur_reg])
            begin
                if (mode_reg == MODE_CLEAR)
                begin
                    ram_we = 1'b1;
                    ram_wdata.seen = 1'b0;
                end
                else if (mode_reg == MODE_FRAME)
                begin
                    ram_we = 1'b1;
                    ram_wdata = upd;
                end
            end
        end
        else if (state_reg == S_FETCH)
        begin
            if (pick_v) ram_raddr = pick;
        end
        else if (state_reg == S_WRITE && mode_reg == MODE_OBSERVE)
        begin
            ram_we = pick_v || free_v_reg;
            ram_waddr = pick_v ? pick : free_reg;
            ram_wdata.seen = 1'b1;
            ram_wdata.x = x_reg;
            ram_wdata.y = y_reg;
            if (!pick_v)
            begin
                ram_wdata.tracked = 1'b0;
                ram_wdata.hits = '0;
                ram_wdata.misses = '0;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gate_reg <= 24'd2500;
            ratio_reg <= 8'd5;
            limit_reg <= 16'd10;
            begin_reg <= '0;
            stop_reg <= '0;
            valid_reg <= '0;
            tracked_reg <= '0;
            done <= 1'b0;
            cur_v_reg <= 1'b0;
            outcome <= OUT_DONE;
            slot <= '0;
            tracked_count <= '0;
            detected_count <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GATE:  gate_reg <= cfg_data[23:0];
                    REG_RATIO: ratio_reg <= cfg_data[7:0];
                    REG_LIMIT: limit_reg <= cfg_data[15:0];
                    REG_BEGIN: begin_reg <= cfg_data;
                    REG_STOP:  stop_reg <= cfg_data;
                    default:   ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg <= mode;
                        x_reg <= x_coord;
                        y_reg <= y_coord;
                        rd_ptr_reg <= '0;
                        cur_v_reg <= 1'b0;
                        bt_v_reg <= 1'b0;
                        bd_v_reg <= 1'b0;
                        free_v_reg <= 1'b0;
                        outcome_reg <= OUT_DONE;
                        slot_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_DRAIN:
                begin
                    if (cur_v_reg)
                    begin
                        if (!valid_reg[cur_reg])
                        begin
                            if (!free_v_reg)
                            begin
                                free_v_reg <= 1'b1;
                                free_reg <= cur_reg;
                            end
                        end
                        else if (mode_reg == MODE_OBSERVE && in_gate)
                        begin
                            if (tracked_reg[cur_reg])
                            begin
                                if (!bt_v_reg || dsq < dt_reg)
                                begin
                                    bt_v_reg <= 1'b1;
                                    bt_reg <= cur_reg;
                                    dt_reg <= dsq;
                                end
                            end
                            else if (!bd_v_reg || dsq < dd_reg)
                            begin
                                bd_v_reg <= 1'b1;
                                bd_reg <= cur_reg;
                                dd_reg <= dsq;
                            end
                        end
                        else if (mode_reg == MODE_FRAME)
                        begin
                            tracked_reg[cur_reg] <= upd.tracked;
                            if (drop) valid_reg[cur_reg] <= 1'b0;
                        end
                    end
                    cur_reg <= rd_ptr_reg[AW-1:0];
                    if (state_reg == S_SCAN)
                    begin
                        cur_v_reg <= 1'b1;
                        if (rd_ptr_reg == CW'(SLOTS - 1))
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            rd_ptr_reg <= rd_ptr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cur_v_reg <= 1'b0;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (mode_reg == MODE_OBSERVE)
                    begin
                        if (pick_v)
                        begin
                            outcome_reg <= pick_d ? OUT_DETECTED : OUT_TRACKED;
                            slot_reg <= pick;
                        end
                        else if (free_v_reg)
                        begin
                            valid_reg[free_reg] <= 1'b1;
                            tracked_reg[free_reg] <= 1'b0;
                            outcome_reg <= OUT_CREATED;
                            slot_reg <= free_reg;
                        end
                        else
                        begin
                            outcome_reg <= OUT_FULL;
                        end
                    end
                    cnt_ptr_reg <= '0;
                    tc_reg <= '0;
                    dc_reg <= '0;
                    state_reg <= S_COUNT;
                end
                S_COUNT:
                begin
                    if (valid_reg[cnt_ptr_reg[AW-1:0]])
                    begin
                        if (tracked_reg[cnt_ptr_reg[AW-1:0]]) tc_reg <= tc_reg + 1'b1;
                        else dc_reg <= dc_reg + 1'b1;
                    end
                    if (cnt_ptr_reg == CW'(SLOTS - 1)) state_reg <= S_DONE;
                    else cnt_ptr_reg <= cnt_ptr_reg + 1'b1;
                end
                S_DONE:
                begin
                    done <= 1'b1;
                    outcome <= outcome_reg;
                    slot <= slot_reg;
                    tracked_count <= tc_reg;
                    detected_count <= dc_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (done && !busy))
        else $error("done strobe missing after count");
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("configuration open while busy");
    a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, tracked_count} + {1'b0, detected_count} <= (CW + 1)'(SLOTS)))
        else $error("entry counts exceed table size");
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (outcome == OUT_FULL || outcome == OUT_DONE)) |-> (slot == '0))
        else $error("slot set without match");
`endif
endmodule
